// File: rtl/at_fsp_pkg.sv
// ----------------------------------------------------------------------------
// AT final status parser package
// Types and character tables shared by the top level and the prefix matcher.
// ----------------------------------------------------------------------------
package at_fsp_pkg;

	// Candidate bit positions in the alive mask.
	localparam int unsigned CAND_OK  = 0;
	localparam int unsigned CAND_ERR = 1;
	localparam int unsigned CAND_CME = 2;
	localparam int unsigned CAND_CMS = 3;

	// Text lengths of the candidates.
	localparam logic [3:0] OK_LEN  = 4'd2;
	localparam logic [3:0] ERR_LEN = 4'd5;
	localparam logic [3:0] PFX_LEN = 4'd11;

	// Final result kinds reported on the output channel.
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_OK   = 3'd1;
	localparam logic [2:0] KIND_ERR  = 3'd2;
	localparam logic [2:0] KIND_CME  = 3'd3;
	localparam logic [2:0] KIND_CMS  = 3'd4;

	// Per-line parser state.
	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  pos;
		logic [3:0]  alive;
		logic [31:0] mag;
		logic        too_large;
		logic        minus;
		logic        digit_seen;
		logic        cut;
	} line_state_t;

	// Outcome of matching one byte against the candidate texts.
	typedef struct packed {
		logic [3:0] alive;
		logic [3:0] pos;
		logic       to_lead;
	} match_res_t;

	function automatic logic [7:0] ok_char(input logic [3:0] p);
		logic [7:0] c;
		case (p)
			4'd0:    c = "O";
			4'd1:    c = "K";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] err_char(input logic [3:0] p);
		logic [7:0] c;
		case (p)
			4'd0:        c = "E";
			4'd1, 4'd2:  c = "R";
			4'd3:        c = "O";
			4'd4:        c = "R";
			default:     c = 8'h00;
		endcase
		return c;
	endfunction

	// Character of "+CME ERROR:" or, with cms set, of "+CMS ERROR:".
	function automatic logic [7:0] pfx_char(input logic [3:0] p, input logic cms);
		logic [7:0] c;
		case (p)
			4'd0:    c = "+";
			4'd1:    c = "C";
			4'd2:    c = "M";
			4'd3:    c = cms ? "S" : "E";
			4'd4:    c = " ";
			4'd5:    c = "E";
			4'd6:    c = "R";
			4'd7:    c = "R";
			4'd8:    c = "O";
			4'd9:    c = "R";
			4'd10:   c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/at_fsp_in_if.sv
// ----------------------------------------------------------------------------
// AT final status parser input channel
// Carries one byte of a response line with its presence and line end marks.
// ----------------------------------------------------------------------------
interface at_fsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] line_byte;
	logic       byte_present;
	logic       line_end;

	modport source (output valid, line_byte, byte_present, line_end, input ready);
	modport sink   (input valid, line_byte, byte_present, line_end, output ready);
endinterface

// File: rtl/at_fsp_out_if.sv
// ----------------------------------------------------------------------------
// AT final status parser output channel
// Carries the final result kind of a line and its numeric error code.
// ----------------------------------------------------------------------------
interface at_fsp_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         final_kind;
	logic signed [31:0] result_code;

	modport source (output valid, final_kind, result_code, input ready);
	modport sink   (input valid, final_kind, result_code, output ready);
endinterface

// File: rtl/at_final_status_parser_top.sv
// ----------------------------------------------------------------------------
// AT final status parser
// Classifies a modem response line as OK, ERROR, +CME ERROR or +CMS ERROR.
// ----------------------------------------------------------------------------
// A line's result is registered after its line-end item leaves the input stage.
// Throughput: one item per cycle while not stalled; one registered pass per byte.
// The input stage stalls only while a line-end item waits for a full result register.
// Reset: arst_n clears the input valid, the line state and the result valid at once.
// After every line end the line state returns to its cleared value.
// ----------------------------------------------------------------------------
module at_final_status_parser_top (
	input  logic         clk,
	input  logic         arst_n,
	at_fsp_in_if.sink    in_ch,
	at_fsp_out_if.source out_ch
);
	import at_fsp_pkg::*;

	// Line phases.
	localparam logic [2:0] PH_PREFIX = 3'd0;
	localparam logic [2:0] PH_LEAD   = 3'd1;
	localparam logic [2:0] PH_NUM    = 3'd2;
	localparam logic [2:0] PH_TRAIL  = 3'd3;
	localparam logic [2:0] PH_BAD    = 3'd4;

	localparam logic [31:0] CODE_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] CODE_NONE = 32'hFFFF_FFFF;

	localparam line_state_t LINE_CLEAR = '{
		phase: PH_PREFIX, pos: 4'd0, alive: 4'hF, mag: 32'd0,
		too_large: 1'b0, minus: 1'b0, digit_seen: 1'b0, cut: 1'b0
	};

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       present_s1;
	logic       end_s1;

	// Line state and result register.
	line_state_t st_q;
	line_state_t st_nxt;
	logic        out_valid_q;
	logic [2:0]  kind_q;
	logic [31:0] code_q;

	logic        advance;
	logic        in_ready;
	match_res_t  mres;
	logic [34:0] dig_v;
	logic        dig_big;
	logic        is_space;
	logic        is_blank;
	logic        is_digit;
	logic [2:0]  kind_nxt;
	logic [31:0] code_nxt;

	// The staged item moves on unless it closes a line and the result
	// register still holds an untaken result.
	assign advance  = valid_s1 && (!end_s1 || !out_valid_q || out_ch.ready);
	assign in_ready = !valid_s1 || advance;
	assign in_ch.ready = in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_ch.valid) begin
			byte_s1    <= in_ch.line_byte;
			present_s1 <= in_ch.byte_present;
			end_s1     <= in_ch.line_end;
		end
	end

	at_fsp_match u_match (
		.line_byte (byte_s1),
		.alive     (st_q.alive),
		.pos       (st_q.pos),
		.res       (mres)
	);

	// Character classes and the next decimal value, magnitude times ten
	// plus the digit, built from two shifts.
	always_comb begin
		is_blank = (byte_s1 == " ") || (byte_s1 == 8'h09);
		is_space = (byte_s1 == " ") || ((byte_s1 >= 8'h09) && (byte_s1 <= 8'h0D));
		is_digit = (byte_s1 >= "0") && (byte_s1 <= "9");
		dig_v    = {st_q.mag, 3'b000} + {2'b00, st_q.mag, 1'b0} + {31'd0, byte_s1[3:0]};
		dig_big  = st_q.too_large || (dig_v > {3'b000, CODE_MAX});
	end

	// Next line state after the staged byte.
	always_comb begin
		st_nxt = st_q;
		if (present_s1 && !st_q.cut) begin
			if (byte_s1 == 8'h00) begin
				// A zero byte ends the text; later bytes of the line are dropped.
				st_nxt.cut = 1'b1;
			end else begin
				unique case (st_q.phase)
					PH_PREFIX: begin
						if (st_q.alive != 4'd0) begin
							st_nxt.alive = mres.alive;
							st_nxt.pos   = mres.pos;
							if (mres.to_lead) begin
								st_nxt.phase = PH_LEAD;
							end
						end
					end
					PH_LEAD: begin
						if (is_space) begin
							st_nxt.phase = PH_LEAD;
						end else if ((byte_s1 == "+") || (byte_s1 == "-")) begin
							st_nxt.minus = (byte_s1 == "-");
							st_nxt.phase = PH_NUM;
						end else if (is_digit) begin
							st_nxt.digit_seen = 1'b1;
							st_nxt.too_large  = dig_big;
							st_nxt.mag        = dig_big ? CODE_MAX : dig_v[31:0];
							st_nxt.phase      = PH_NUM;
						end else begin
							st_nxt.phase = PH_BAD;
						end
					end
					PH_NUM: begin
						if (is_digit) begin
							st_nxt.digit_seen = 1'b1;
							st_nxt.too_large  = dig_big;
							st_nxt.mag        = dig_big ? CODE_MAX : dig_v[31:0];
						end else if (is_blank && st_q.digit_seen) begin
							st_nxt.phase = PH_TRAIL;
						end else begin
							st_nxt.phase = PH_BAD;
						end
					end
					PH_TRAIL: begin
						if (!is_blank) begin
							st_nxt.phase = PH_BAD;
						end
					end
					default: begin
						st_nxt.phase = st_q.phase;
					end
				endcase
			end
		end
	end

	// Result of a line. OK and ERROR need the whole line to match; the
	// prefixed kinds report the code only when it is well formed, not
	// negative and in range. A minus sign before zero still gives zero.
	always_comb begin
		kind_nxt = KIND_NONE;
		code_nxt = CODE_NONE;
		if (st_nxt.phase == PH_PREFIX) begin
			if (st_nxt.alive[CAND_OK] && (st_nxt.pos == OK_LEN)) begin
				kind_nxt = KIND_OK;
			end else if (st_nxt.alive[CAND_ERR] && (st_nxt.pos == ERR_LEN)) begin
				kind_nxt = KIND_ERR;
			end
		end else begin
			kind_nxt = st_nxt.alive[CAND_CME] ? KIND_CME : KIND_CMS;
			if (((st_nxt.phase == PH_NUM) || (st_nxt.phase == PH_TRAIL)) &&
				st_nxt.digit_seen && !st_nxt.too_large &&
				!(st_nxt.minus && (st_nxt.mag != 32'd0))) begin
				code_nxt = st_nxt.mag;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= LINE_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				st_q <= end_s1 ? LINE_CLEAR : st_nxt;
			end
			if (advance && end_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && end_s1) begin
			kind_q <= kind_nxt;
			code_q <= code_nxt;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.final_kind  = kind_q;
	assign out_ch.result_code = code_q;

`ifndef ASSERT_OFF
	// Kinds without a number always carry the absent code.
	a_plain_kind_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((kind_q == KIND_NONE) || (kind_q == KIND_OK) ||
		(kind_q == KIND_ERR)) |-> (code_q == CODE_NONE))
		else $error("plain kind carries a numeric code");

	// A reported code is either absent or non-negative.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!code_q[31] || (code_q == CODE_NONE)))
		else $error("negative error code reported");

	// Leaving the prefix phase needs a full prefix match of a prefixed kind.
	a_prefix_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase != PH_PREFIX) |->
		((st_q.pos == PFX_LEN) && (st_q.alive[CAND_CMS:CAND_CME] != 2'b00)))
		else $error("number phase entered without a full prefix");

	// An accepted line end produces a result in the next cycle.
	a_line_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && end_s1) |=> out_valid_q)
		else $error("line end without a result");
`endif

endmodule

// File: rtl/at_fsp_match.sv
// ----------------------------------------------------------------------------
// AT final status parser prefix matcher
// Compares one byte against the four candidate texts at the current position.
// ----------------------------------------------------------------------------
module at_fsp_match (
	input  logic [7:0]             line_byte,
	input  logic [3:0]             alive,
	input  logic [3:0]             pos,
	output at_fsp_pkg::match_res_t res
);
	import at_fsp_pkg::*;

	logic [3:0] hit;
	logic [3:0] alive_nxt;
	logic [3:0] pos_inc;

	always_comb begin
		hit[CAND_OK]  = (pos < OK_LEN)  && (ok_char(pos) == line_byte);
		hit[CAND_ERR] = (pos < ERR_LEN) && (err_char(pos) == line_byte);
		hit[CAND_CME] = (pos < PFX_LEN) && (pfx_char(pos, 1'b0) == line_byte);
		hit[CAND_CMS] = (pos < PFX_LEN) && (pfx_char(pos, 1'b1) == line_byte);
		alive_nxt     = alive & hit;
		pos_inc       = pos + 4'd1;
	end

	// A dead mask freezes the position, so the line can no longer match.
	always_comb begin
		res.alive   = alive_nxt;
		res.pos     = (alive_nxt != 4'd0) ? pos_inc : pos;
		res.to_lead = (alive_nxt != 4'd0) && (pos_inc == PFX_LEN) &&
			(alive_nxt[CAND_CMS:CAND_CME] != 2'b00);
	end
endmodule
